### hw/rtl/xkcf_pkg.sv
package xkcf_pkg;

  localparam int VALUE_BITS   = 8;
  localparam int ROW_BITS     = 16;
  localparam int CFG_LEN_BITS = 7;
  localparam int OUT_COL_BITS = 6;
  localparam int OUT_CNT_BITS = 16;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam logic [ROW_BITS-1:0]   ROW_MAX   = '1;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  localparam logic [CFG_LEN_BITS-1:0] KEY_LENGTH_RESET = 7'd1;
  localparam logic [VALUE_BITS-1:0]   GUESS_RESET      = 8'd32;

  // register indexes
  typedef enum logic {
    REG_KEY_LENGTH = 1'b0,
    REG_GUESS      = 1'b1
  } reg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic clr;         // write zero at the sweep address
    logic scan;        // read at the sweep address for winner search
    logic text_clear;  // reset column/row indices and high-water mark
  } ctl_cmd_t;

endpackage

### hw/rtl/xkcf_ctrl.sv
module xkcf_ctrl
  import xkcf_pkg::*;
#(
  parameter int KEY_MAX = 64,
  parameter int CW      = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  end_accept,
  input  logic [CW-1:0]         sweep_last,
  output ctl_cmd_t              cmd,
  output logic [CW-1:0]         scan_col,
  output logic [VALUE_BITS-1:0] scan_val,
  output logic                  busy
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAIN,
    ST_SCAN,
    ST_TAIL
  } state_t;

  localparam logic [CW-1:0] COL_TOP = CW'(KEY_MAX - 1);

  state_t                  state_r, state_nxt;
  logic                    busy_r;
  logic [CW-1:0]           scan_col_r, scan_col_nxt;
  logic [VALUE_BITS-1:0]   scan_val_r, scan_val_nxt;
  logic [CW-1:0]           last_col;
  logic                    sweep_end;

  always_comb begin
    last_col  = (state_r == ST_CLEAR) ? COL_TOP : sweep_last;
    sweep_end = (scan_col_r == last_col) && (scan_val_r == VALUE_MAX);
  end

  always_comb begin
    state_nxt    = state_r;
    scan_col_nxt = scan_col_r;
    scan_val_nxt = scan_val_r;
    cmd          = '0;
    case (state_r)
      ST_CLEAR, ST_SCAN: begin
        cmd.clr  = 1'b1;
        cmd.scan = (state_r == ST_SCAN);
        scan_val_nxt = scan_val_r + 1'b1;
        if (scan_val_r == VALUE_MAX) begin
          scan_col_nxt = scan_col_r + 1'b1;
        end
        if (sweep_end) begin
          scan_col_nxt = '0;
          scan_val_nxt = '0;
          state_nxt    = (state_r == ST_CLEAR) ? ST_IDLE : ST_TAIL;
        end
      end
      ST_IDLE: begin
        if (end_accept) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_SCAN;
      end
      ST_TAIL: begin
        cmd.text_clear = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      busy_r     <= 1'b1;
      scan_col_r <= '0;
      scan_val_r <= '0;
    end else begin
      state_r    <= state_nxt;
      busy_r     <= (state_nxt != ST_IDLE);
      scan_col_r <= scan_col_nxt;
      scan_val_r <= scan_val_nxt;
    end
  end

  assign scan_col = scan_col_r;
  assign scan_val = scan_val_r;
  assign busy     = busy_r;

`ifndef SYNTH
  a_idle_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> state_r == ST_IDLE)
    else $error("busy low outside idle");

  a_drain_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |=> state_r == ST_SCAN)
    else $error("drain did not lead to scan");

  a_col_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && scan_val_r != VALUE_MAX) |=> scan_col_r == $past(scan_col_r))
    else $error("column advanced mid-column");
`endif

endmodule

### hw/rtl/xkcf_datapath.sv
module xkcf_datapath
  import xkcf_pkg::*;
#(
  parameter int KEY_MAX    = 64,
  parameter int COUNT_BITS = 16,
  parameter int CW         = 6,
  parameter int LW         = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctl_cmd_t                cmd,
  input  logic [CW-1:0]           scan_col,
  input  logic [VALUE_BITS-1:0]   scan_val,
  input  logic                    accept,
  input  logic [VALUE_BITS-1:0]   in_cipher_byte,
  input  logic [CFG_LEN_BITS-1:0] key_length,
  input  logic [VALUE_BITS-1:0]   guess,
  output logic [CW-1:0]           sweep_last,
  output logic                    out_strobe,
  output logic [VALUE_BITS-1:0]   out_key_byte,
  output logic [OUT_COL_BITS-1:0] out_column,
  output logic [OUT_CNT_BITS-1:0] out_top_count,
  output logic                    out_last_key
);

  localparam int AW    = CW + VALUE_BITS;
  localparam int DEPTH = KEY_MAX * 256;
  localparam int MW    = ROW_BITS + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_LIMIT = '1;

  // {row, count} per (column, value)
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rd_word_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [MW-1:0] wr_word;
  logic          wr_en;

  logic [LW-1:0]       klen;
  logic [CW-1:0]       col_r, col_nxt, col_a;
  logic [ROW_BITS-1:0] row_r, row_nxt, row_a;
  logic [LW-1:0]       hw_r, hw_cand, sweep_n;
  logic [31:0]         col_b;
  logic                wrap0, wrap1;

  logic                  s1_vld_r;
  logic [AW-1:0]         s1_slot_r;
  logic [ROW_BITS-1:0]   s1_row_r;
  logic                  fw_vld_r;
  logic [AW-1:0]         fw_slot_r;
  logic [COUNT_BITS-1:0] fw_cnt_r;
  logic [COUNT_BITS-1:0] s1_cnt, s1_cnt_inc;

  logic                  p_vld_r, p_last_r;
  logic [CW-1:0]         p_col_r;
  logic [VALUE_BITS-1:0] p_val_r;
  logic [COUNT_BITS-1:0] best_cnt_r, rd_cnt, cur_cnt;
  logic [ROW_BITS-1:0]   best_row_r, rd_row, cur_row;
  logic [VALUE_BITS-1:0] best_val_r, cur_val;
  logic                  take;

  logic                    out_strobe_r;
  logic [VALUE_BITS-1:0]   out_key_byte_r;
  logic [OUT_COL_BITS-1:0] out_column_r;
  logic [OUT_CNT_BITS-1:0] out_top_count_r;
  logic                    out_last_key_r;

  // effective key length: zero reads as one, above KEY_MAX saturates
  always_comb begin
    if (key_length == '0) begin
      klen = LW'(1);
    end else if (32'(key_length) > 32'(KEY_MAX)) begin
      klen = LW'(KEY_MAX);
    end else begin
      klen = LW'(key_length);
    end
  end

  // column/row stepping for an accepted byte
  always_comb begin
    wrap0   = 32'(col_r) >= 32'(klen);
    col_a   = wrap0 ? '0 : col_r;
    row_a   = (wrap0 && row_r != ROW_MAX) ? row_r + 1'b1 : row_r;
    col_b   = 32'(col_a) + 32'd1;
    wrap1   = col_b >= 32'(klen);
    col_nxt = wrap1 ? '0 : CW'(col_b);
    row_nxt = (wrap1 && row_a != ROW_MAX) ? row_a + 1'b1 : row_a;
    hw_cand = LW'(col_b);
    sweep_n = (hw_r > klen) ? hw_r : klen;
  end

  assign sweep_last = CW'(sweep_n - LW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      hw_r  <= '0;
    end else if (cmd.text_clear) begin
      col_r <= '0;
      row_r <= '0;
      hw_r  <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (hw_cand > hw_r) begin
        hw_r <= hw_cand;
      end
    end
  end

  // count update with forwarding of the previous write
  always_comb begin
    if (fw_vld_r && fw_slot_r == s1_slot_r) begin
      s1_cnt = fw_cnt_r;
    end else begin
      s1_cnt = rd_word_r[COUNT_BITS-1:0];
    end
    s1_cnt_inc = (s1_cnt != CNT_LIMIT) ? s1_cnt + 1'b1 : s1_cnt;
  end

  always_comb begin
    rd_addr = cmd.scan ? {scan_col, scan_val} : {col_a, in_cipher_byte};
    if (cmd.clr) begin
      wr_en   = 1'b1;
      wr_addr = {scan_col, scan_val};
      wr_word = '0;
    end else begin
      wr_en   = s1_vld_r;
      wr_addr = s1_slot_r;
      wr_word = {s1_row_r, s1_cnt_inc};
    end
  end

  always_ff @(posedge clk) begin
    rd_word_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      fw_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      fw_vld_r <= s1_vld_r && !cmd.clr;
    end
    s1_slot_r <= {col_a, in_cipher_byte};
    s1_row_r  <= row_a;
    fw_slot_r <= s1_slot_r;
    fw_cnt_r  <= s1_cnt_inc;
  end

  // winner search: higher count, then later row, then lower value
  always_comb begin
    rd_cnt  = rd_word_r[COUNT_BITS-1:0];
    rd_row  = rd_word_r[MW-1:COUNT_BITS];
    take    = (rd_cnt != '0) &&
              ((rd_cnt > best_cnt_r) || (rd_cnt == best_cnt_r && rd_row > best_row_r));
    cur_cnt = take ? rd_cnt  : best_cnt_r;
    cur_row = take ? rd_row  : best_row_r;
    cur_val = take ? p_val_r : best_val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r      <= 1'b0;
      best_cnt_r   <= '0;
      best_row_r   <= '0;
      best_val_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      p_vld_r      <= cmd.scan;
      out_strobe_r <= 1'b0;
      if (p_vld_r) begin
        if (p_last_r) begin
          best_cnt_r   <= '0;
          best_row_r   <= '0;
          best_val_r   <= '0;
          out_strobe_r <= 32'(p_col_r) < 32'(klen);
        end else begin
          best_cnt_r <= cur_cnt;
          best_row_r <= cur_row;
          best_val_r <= cur_val;
        end
      end
    end
    p_col_r         <= scan_col;
    p_val_r         <= scan_val;
    p_last_r        <= (scan_val == VALUE_MAX);
    out_key_byte_r  <= (cur_cnt != '0) ? (cur_val ^ guess) : '0;
    out_column_r    <= OUT_COL_BITS'(32'(p_col_r));
    out_top_count_r <= OUT_CNT_BITS'(32'(cur_cnt));
    out_last_key_r  <= (32'(p_col_r) + 32'd1) == 32'(klen);
  end

  assign out_strobe    = out_strobe_r;
  assign out_key_byte  = out_key_byte_r;
  assign out_column    = out_column_r;
  assign out_top_count = out_top_count_r;
  assign out_last_key  = out_last_key_r;

`ifndef SYNTH
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(p_vld_r && p_last_r))
    else $error("result without end of column sweep");

  a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr && s1_vld_r))
    else $error("count write collides with clear");

  a_no_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !cmd.scan)
    else $error("byte taken during scan");
`endif

endmodule

### hw/rtl/xor_key_column_frequency_recovery.sv
// Repeating-key XOR key recovery by column frequency. Ciphertext bytes are
// taken one per cycle (start high while busy low); byte n is counted against
// column n mod key_length. The byte flagged end_of_text is counted, then busy
// stays high while the count memory is swept over columns 0 to C-1, where C is
// the larger of key_length and the number of columns used in this text: the
// sweep reads one (column, value) entry per cycle on the memory read port and
// zeroes it on the write port. One transfer per column below key_length leaves
// on the out_ ports, each marked by out_strobe for a single cycle; the receiver
// cannot stall, so it must take every transfer as it comes. Ties on count go
// to the value seen on the later row, then to the lower value. After reset the
// block is busy while the whole count memory is cleared; configuration writes
// are taken throughout and should only be made while busy is low.
module xor_key_column_frequency_recovery
  import xkcf_pkg::*;
#(
  parameter int KEY_MAX    = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [VALUE_BITS-1:0]    in_cipher_byte,
  input  logic                     in_end_of_text,
  output logic                     out_strobe,
  output logic [VALUE_BITS-1:0]    out_key_byte,
  output logic [OUT_COL_BITS-1:0]  out_column,
  output logic [OUT_CNT_BITS-1:0]  out_top_count,
  output logic                     out_last_key,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  // column index width, and width that holds the key length itself
  localparam int CW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int LW = $clog2(KEY_MAX + 1);

  logic [CFG_LEN_BITS-1:0] key_length_r;
  logic [VALUE_BITS-1:0]   guess_r;
  reg_idx_t                reg_idx;
  logic                    cfg_wr;

  ctl_cmd_t              cmd;
  logic [CW-1:0]         scan_col;
  logic [VALUE_BITS-1:0] scan_val;
  logic [CW-1:0]         sweep_last;
  logic                  accept;

  // register file: word index from bit 2 of the byte address
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KEY_LENGTH_RESET;
      guess_r      <= GUESS_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_KEY_LENGTH: key_length_r <= pwdata[CFG_LEN_BITS-1:0];
        REG_GUESS:      guess_r      <= pwdata[VALUE_BITS-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY_LENGTH: prdata = APB_DATA_BITS'(key_length_r);
      REG_GUESS:      prdata = APB_DATA_BITS'(guess_r);
      default:        prdata = '0;
    endcase
  end

  // a transfer is taken whenever the sequencer is idle
  assign accept = start && !busy;

  xkcf_ctrl #(
    .KEY_MAX (KEY_MAX),
    .CW      (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .end_accept (accept && in_end_of_text),
    .sweep_last (sweep_last),
    .cmd        (cmd),
    .scan_col   (scan_col),
    .scan_val   (scan_val),
    .busy       (busy)
  );

  xkcf_datapath #(
    .KEY_MAX    (KEY_MAX),
    .COUNT_BITS (COUNT_BITS),
    .CW         (CW),
    .LW         (LW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .scan_col       (scan_col),
    .scan_val       (scan_val),
    .accept         (accept),
    .in_cipher_byte (in_cipher_byte),
    .key_length     (key_length_r),
    .guess          (guess_r),
    .sweep_last     (sweep_last),
    .out_strobe     (out_strobe),
    .out_key_byte   (out_key_byte),
    .out_column     (out_column),
    .out_top_count  (out_top_count),
    .out_last_key   (out_last_key)
  );

endmodule
